@@ rtl/core/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Request kinds, status codes and channel payload types of the heap queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] push_key;
      logic [31:0] push_value;
   } req_type_t_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] top_key;
      logic [31:0] top_value;
      logic [31:0] removed_key;
      logic [31:0] removed_value;
      logic [6:0]  entry_total;
      logic        is_empty;
   } rsp_payload_type;

endpackage

@@ rtl/core/bmhpq_req_if.sv @@
// ----------------------------------------------------------------------------
// bmhpq_req_if
// Request channel: valid, ready and one request payload.
// ----------------------------------------------------------------------------
interface bmhpq_req_if;
   logic                             valid;
   logic                             ready;
   bmhpq_pkg::req_type_t_type        payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/bmhpq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bmhpq_rsp_if
// Response channel: valid, ready and one response payload.
// ----------------------------------------------------------------------------
interface bmhpq_rsp_if;
   logic                           valid;
   logic                           ready;
   bmhpq_pkg::rsp_payload_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/binary_max_heap_priority_queue.sv @@
// Push sifts the new entry up and pop sifts the tail entry down the heap,
// one heap level per read/compare/write step; query, clear and refused requests do neither.
// Throughput: one request at a time; the single-port-write heap memory sets the pace.
// Reset: synchronous, clears the entry count and control; the heap memory is not cleared.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max priority queue held as a binary heap in one synchronous memory.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 32,
   parameter int VAL_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   bmhpq_req_if.sink    req,
   bmhpq_rsp_if.source  rsp
);
   import bmhpq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = KEY_BITS + VAL_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_PTAIL, S_PLOAD,
      S_DN_RDL, S_DN_RDR, S_DN_CMP, S_FINAL, S_TOP, S_RESP
   } state_type;

   state_type          state_ff;
   logic [EW-1:0]      mem [DEPTH];
   logic [EW-1:0]      rdata_ff;
   logic [AW-1:0]      raddr;
   logic               rd_en;
   logic               wr_en;
   logic [AW-1:0]      waddr;
   logic [EW-1:0]      wdata;

   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      pos_ff;
   logic [EW-1:0]      ent_ff;
   logic [EW-1:0]      left_ff;
   logic               has_right_ff;
   logic [1:0]         status_ff;
   logic [EW-1:0]      removed_ff;
   rsp_payload_type    out_ff;
   logic               out_valid_ff;

   logic [AW:0]        child_l;
   logic [AW-1:0]      parent;
   logic [KEY_BITS-1:0] ent_key, rd_key, left_key;

   assign ent_key  = ent_ff[EW-1 -: KEY_BITS];
   assign rd_key   = rdata_ff[EW-1 -: KEY_BITS];
   assign left_key = left_ff[EW-1 -: KEY_BITS];
   assign child_l  = {pos_ff, 1'b1};
   assign parent   = AW'((pos_ff - 1'b1) >> 1);

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   always_comb begin
      rd_en = 1'b0;
      raddr = '0;
      wr_en = 1'b0;
      waddr = pos_ff;
      wdata = ent_ff;
      case (state_ff)
         S_IDLE: begin
            rd_en = 1'b1;
            raddr = '0;
         end
         S_UP_RD: begin
            rd_en = 1'b1;
            raddr = parent;
         end
         S_UP_CMP: begin
            if (rd_key < ent_key) begin
               wr_en = 1'b1;
               wdata = rdata_ff;
            end
         end
         S_PTAIL: begin
            rd_en = 1'b1;
            raddr = AW'(count_ff);
         end
         S_DN_RDL: begin
            rd_en = 1'b1;
            raddr = AW'(child_l);
         end
         S_DN_RDR: begin
            rd_en = 1'b1;
            raddr = AW'(child_l + 1'b1);
         end
         S_DN_CMP: begin
            if (has_right_ff && rd_key > left_key) begin
               if (ent_key < rd_key) begin
                  wr_en = 1'b1;
                  wdata = rdata_ff;
               end
            end else if (ent_key < left_key) begin
               wr_en = 1'b1;
               wdata = left_ff;
            end
         end
         S_FINAL: begin
            wr_en = 1'b1;
         end
         S_TOP: begin
            rd_en = 1'b1;
            raddr = '0;
         end
         default: ;
      endcase
   end

   assign req.ready   = (state_ff == S_IDLE) && !(out_valid_ff && !rsp.ready);
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  status_ff  <= ST_OK;
                  removed_ff <= '0;
                  ent_ff     <= {req.payload.push_key[KEY_BITS-1:0],
                                 req.payload.push_value[VAL_BITS-1:0]};
                  state_ff   <= S_TOP;
                  case (req_kind_type'(req.payload.req_type))
                     REQ_PUSH: begin
                        if (count_ff == CW'(DEPTH)) begin
                           status_ff <= ST_FULL;
                        end else begin
                           pos_ff   <= AW'(count_ff);
                           count_ff <= count_ff + 1'b1;
                           state_ff <= (count_ff == '0) ? S_FINAL : S_UP_RD;
                        end
                     end
                     REQ_POP: begin
                        if (count_ff == '0) begin
                           status_ff <= ST_EMPTY;
                        end else begin
                           count_ff <= count_ff - 1'b1;
                           state_ff <= S_PTAIL;
                        end
                     end
                     REQ_CLEAR: count_ff <= '0;
                     default: ;
                  endcase
               end
            end
            S_UP_RD: state_ff <= S_UP_CMP;
            S_UP_CMP: begin
               if (rd_key < ent_key) begin
                  pos_ff   <= parent;
                  state_ff <= (parent == '0) ? S_FINAL : S_UP_RD;
               end else begin
                  state_ff <= S_FINAL;
               end
            end
            S_PTAIL: begin
               removed_ff <= rdata_ff;
               pos_ff     <= '0;
               state_ff   <= S_PLOAD;
            end
            S_PLOAD: begin
               ent_ff   <= rdata_ff;
               state_ff <= (count_ff > CW'(1)) ? S_DN_RDL : S_FINAL;
            end
            S_DN_RDL: state_ff <= S_DN_RDR;
            S_DN_RDR: begin
               left_ff      <= rdata_ff;
               has_right_ff <= (CW'(child_l) + 1'b1) < count_ff;
               state_ff     <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (has_right_ff && rd_key > left_key) begin
                  if (ent_key < rd_key) begin
                     pos_ff   <= AW'(child_l + 1'b1);
                     state_ff <= ((CW'(child_l) + 1'b1) * 2 + 1 < count_ff)
                                 ? S_DN_RDL : S_FINAL;
                  end else begin
                     state_ff <= S_FINAL;
                  end
               end else if (ent_key < left_key) begin
                  pos_ff   <= AW'(child_l);
                  state_ff <= (CW'(child_l) * 2 + 1 < count_ff) ? S_DN_RDL : S_FINAL;
               end else begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: state_ff <= S_TOP;
            S_TOP:   state_ff <= S_RESP;
            S_RESP: begin
               out_ff.status        <= status_ff;
               out_ff.top_key       <= (count_ff == '0) ? '0 :
                                       32'(rdata_ff[EW-1 -: KEY_BITS]);
               out_ff.top_value     <= (count_ff == '0) ? '0 :
                                       32'(rdata_ff[VAL_BITS-1:0]);
               out_ff.removed_key   <= 32'(removed_ff[EW-1 -: KEY_BITS]);
               out_ff.removed_value <= 32'(removed_ff[VAL_BITS-1:0]);
               out_ff.entry_total   <= 7'(count_ff);
               out_ff.is_empty      <= (count_ff == '0);
               out_valid_ff         <= 1'b1;
               state_ff             <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("entry count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_resp_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |=> out_valid_ff) else $error("response not raised");
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.is_empty == (out_ff.entry_total == '0))
      else $error("empty flag mismatch");
`endif

endmodule

@@ verif/binary_max_heap_priority_queue_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_chk
// Watches the request and response channels of the heap queue, keeps its own
// heap to predict each response and compares the responses field by field.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_chk #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   bmhpq_req_if        req,
   bmhpq_rsp_if        rsp,
   output int          fail_count,
   output int          pending_count
);
   import bmhpq_pkg::*;

   logic [31:0]     heap_keys [DEPTH];
   logic [31:0]     heap_vals [DEPTH];
   int              held;
   rsp_payload_type expected_rsps [$];

   function automatic rsp_payload_type apply_request(req_type_t_type r);
      rsp_payload_type o;
      int              pos;
      int              up;
      int              c;
      logic [31:0]     k;
      logic [31:0]     v;
      o = '0;
      o.status = ST_OK;
      case (req_kind_type'(r.req_type))
         REQ_PUSH: begin
            if (held >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               pos = held;
               k = r.push_key;
               v = r.push_value;
               held++;
               while (pos != 0) begin
                  up = (pos - 1) / 2;
                  if (k <= heap_keys[up]) break;
                  heap_keys[pos] = heap_keys[up];
                  heap_vals[pos] = heap_vals[up];
                  pos = up;
               end
               heap_keys[pos] = k;
               heap_vals[pos] = v;
            end
         end
         REQ_POP: begin
            if (held == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.removed_key = heap_keys[0];
               o.removed_value = heap_vals[0];
               held--;
               k = heap_keys[held];
               v = heap_vals[held];
               pos = 0;
               forever begin
                  c = 2 * pos + 1;
                  if (c >= held) break;
                  if (c + 1 < held && heap_keys[c + 1] > heap_keys[c]) c++;
                  if (k >= heap_keys[c]) break;
                  heap_keys[pos] = heap_keys[c];
                  heap_vals[pos] = heap_vals[c];
                  pos = c;
               end
               heap_keys[pos] = k;
               heap_vals[pos] = v;
            end
         end
         REQ_CLEAR: held = 0;
         default: ;
      endcase
      o.top_key = held != 0 ? heap_keys[0] : '0;
      o.top_value = held != 0 ? heap_vals[0] : '0;
      o.entry_total = held[6:0];
      o.is_empty = held == 0;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type e;
      rsp_payload_type a;
      if (reset) begin
         held = 0;
         fail_count <= 0;
         expected_rsps.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            a = rsp.payload;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (a != e) begin
                  fail_count <= fail_count + 1;
                  if (a.status != e.status)
                     $error("status exp %0d got %0d", e.status, a.status);
                  if (a.top_key != e.top_key)
                     $error("top_key exp %h got %h", e.top_key, a.top_key);
                  if (a.top_value != e.top_value)
                     $error("top_value exp %h got %h", e.top_value, a.top_value);
                  if (a.removed_key != e.removed_key)
                     $error("removed_key exp %h got %h", e.removed_key, a.removed_key);
                  if (a.removed_value != e.removed_value)
                     $error("removed_value exp %h got %h", e.removed_value,
                            a.removed_value);
                  if (a.entry_total != e.entry_total)
                     $error("entry_total exp %0d got %0d", e.entry_total,
                            a.entry_total);
                  if (a.is_empty != e.is_empty)
                     $error("is_empty exp %0d got %0d", e.is_empty, a.is_empty);
               end
            end
         end
         if (req.valid && req.ready) expected_rsps.push_back(apply_request(req.payload));
      end
      pending_count = expected_rsps.size();
   end

endmodule

@@ verif/binary_max_heap_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_tb
// Drives directed and random push, pop, clear and query requests with random
// gaps and response stalls, including a fill to capacity; a checker module
// predicts and compares every response.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_tb;
   import bmhpq_pkg::*;

   localparam int DEPTH = 64;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   rsp_hold;
   bit   stim_done;

   bmhpq_req_if req_ch ();
   bmhpq_rsp_if rsp_ch ();

   binary_max_heap_priority_queue #(.DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   binary_max_heap_priority_queue_chk #(.DEPTH(DEPTH)) checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("binary_max_heap_priority_queue_tb: errors");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(req_kind_type kind, logic [31:0] key, logic [31:0] val,
                               bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g != 0) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '{req_type: kind, push_key: $urandom, push_value: $urandom};
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{req_type: kind, push_key: key, push_value: val};
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   task automatic push_rand(bit gaps);
      send_request(REQ_PUSH, rand_word(), $urandom, gaps);
   endtask

   initial begin
      int g;
      bit hold_done;
      rsp_ch.ready = 1'b0;
      hold_done = 0;
      @(negedge clock);
      while (!stim_done || pending_count != 0) begin
         if (rsp_hold && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_done = 1;
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
         if ($urandom_range(0, 2) == 0) begin
            g = gap_len();
            if (g != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
      rsp_ch.ready <= 1'b1;
   end

   initial begin
      int n;
      int kind;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      reset = 1'b1;
      rsp_hold = 0;
      stim_done = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(REQ_POP, 0, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0);
      send_request(REQ_PUSH, 32'h0, 32'hFFFF_FFFF, 0);
      send_request(REQ_PUSH, 32'hFFFF_FFFF, 32'h0, 0);
      send_request(REQ_PUSH, 32'h5, 32'h1, 0);
      send_request(REQ_PUSH, 32'h5, 32'h2, 0);
      send_request(REQ_PUSH, 32'h5, 32'h3, 0);
      send_request(REQ_PUSH, 32'hFFFF_FFFF, 32'hAAAA_5555, 0);
      send_request(REQ_QUERY, 0, 0, 0);
      repeat (6) send_request(REQ_POP, 0, 0, 0);
      send_request(REQ_PUSH, 32'h7, 32'h7, 0);
      send_request(REQ_CLEAR, 0, 0, 0);
      send_request(REQ_POP, 0, 0, 0);

      rsp_hold = 1;
      repeat (DEPTH + 3) push_rand(0);
      send_request(REQ_QUERY, 0, 0, 0);
      repeat (DEPTH + 2) send_request(REQ_POP, 0, 0, 0);
      drain();

      n = 0;
      while (n < 1450) begin
         kind = $urandom_range(0, 99);
         if (kind < 5) begin
            send_request(REQ_CLEAR, 0, 0, 1);
            n++;
         end else if (kind < 10) begin
            repeat ($urandom_range(20, 70)) begin
               push_rand(1);
               n++;
            end
         end else if (kind < 15) begin
            repeat ($urandom_range(10, 70)) begin
               send_request(REQ_POP, 0, 0, 1);
               n++;
            end
         end else if (kind < 55) begin
            push_rand(1);
            n++;
         end else if (kind < 90) begin
            send_request(REQ_POP, 0, 0, 1);
            n++;
         end else begin
            send_request(REQ_QUERY, $urandom, $urandom, 1);
            n++;
         end
         if (n > 700 && n < 720) drain();
      end

      stim_done = 1;
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("binary_max_heap_priority_queue_tb: clean");
      else
         $display("binary_max_heap_priority_queue_tb: errors");
      $finish;
   end

endmodule
